### hw/rtl/sliru_pkg.sv
// Package for the sorted list insert/remove unit.
// Holds widths, operation and status codes, and the cell control struct.
// No dependencies.
package sliru_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = 6;
  localparam int STAT_W   = 3;
  localparam int OP_W     = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_REMOVED   = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_DUMPED    = 3'd4;
  localparam logic [STAT_W-1:0] STATUS_EMPTY     = 3'd5;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  key;
    logic [CNT_W-1:0]          count;
  } cell_ctl_t;

endpackage

### hw/rtl/sliru_cell.sv
// One storage cell of the sorted list chain.
// Holds one value; shifts from a neighbour on insert, remove and rotate.
// Depends on sliru_pkg.
module sliru_cell (
  input  logic                               clk,
  input  sliru_pkg::cell_ctl_t               ctl,
  input  logic [sliru_pkg::IDX_W-1:0]        idx,
  input  logic                               prev_lt,
  input  logic signed [sliru_pkg::DATA_W-1:0] prev_val,
  input  logic signed [sliru_pkg::DATA_W-1:0] next_val,
  input  logic signed [sliru_pkg::DATA_W-1:0] head_val,
  output logic signed [sliru_pkg::DATA_W-1:0] val,
  output logic                               lt,
  output logic                               eq
);

  logic signed [sliru_pkg::DATA_W-1:0] val_r;
  logic signed [sliru_pkg::DATA_W-1:0] val_nxt;
  logic                                occupied;
  logic                                tail;

  assign occupied = sliru_pkg::CNT_W'(idx) < ctl.count;
  assign tail     = sliru_pkg::CNT_W'(idx) == (ctl.count - 1'b1);
  assign lt       = occupied && (val_r < ctl.key);
  assign eq       = occupied && (val_r == ctl.key);
  assign val      = val_r;

  always_comb begin
    case (ctl.cmd)
      sliru_pkg::CMD_INSERT: begin
        if (lt) begin
          val_nxt = val_r;
        end else if (prev_lt) begin
          val_nxt = ctl.key;
        end else begin
          val_nxt = prev_val;
        end
      end
      sliru_pkg::CMD_REMOVE: begin
        val_nxt = lt ? val_r : next_val;
      end
      sliru_pkg::CMD_ROTATE: begin
        val_nxt = tail ? head_val : next_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### hw/rtl/sorted_list_insert_remove_unit.sv
// Sorted list insert/remove unit: a chain of value cells kept in ascending order.
// Insert and remove take one transaction per cycle while out_tready does not hold the
// result, registered at the accepting edge. Unknown operations are taken and produce no
// result. A dump of an empty list returns an empty status; otherwise the unit emits one
// result per cycle unless stalled as the chain rotates past its head, taking no input.
// Synchronous active-low reset empties the list; cells are not cleared. Uses sliru_pkg.
module sorted_list_insert_remove_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] operation, [33:2] value, [39:34] zero
  input  logic [sliru_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [34:3] item, [40:35] count, [47:41] zero
  output logic [sliru_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast
);

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  localparam int CAP = sliru_pkg::CAPACITY;
  localparam int DW  = sliru_pkg::DATA_W;

  state_t                          state_r, state_nxt;
  logic [sliru_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [sliru_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sliru_pkg::STAT_W-1:0]    out_status_r, out_status_nxt;
  logic signed [DW-1:0]            out_item_r, out_item_nxt;
  logic [sliru_pkg::CNT_W-1:0]     out_count_r, out_count_nxt;
  logic                            out_last_r, out_last_nxt;

  sliru_pkg::cell_ctl_t            ctl;
  logic [sliru_pkg::OP_W-1:0]      op;
  logic signed [DW-1:0]            key;
  logic                            out_free;
  logic                            in_acc;
  logic                            found;
  logic                            full;
  logic                            dump_last;

  logic signed [DW-1:0]            cell_val [CAP];
  logic                            cell_lt  [CAP];
  logic [CAP-1:0]                  cell_eq;

  assign op  = in_tdata[sliru_pkg::OP_W-1:0];
  assign key = in_tdata[sliru_pkg::OP_W +: DW];

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic                 prev_lt;
    logic signed [DW-1:0] prev_val;
    logic signed [DW-1:0] next_val;

    if (g == 0) begin : g_head
      assign prev_lt  = 1'b1;
      assign prev_val = key;
    end else begin : g_body
      assign prev_lt  = cell_lt[g-1];
      assign prev_val = cell_val[g-1];
    end

    if (g == CAP - 1) begin : g_end
      assign next_val = '0;
    end else begin : g_mid
      assign next_val = cell_val[g+1];
    end

    sliru_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (sliru_pkg::IDX_W'(g)),
      .prev_lt  (prev_lt),
      .prev_val (prev_val),
      .next_val (next_val),
      .head_val (cell_val[0]),
      .val      (cell_val[g]),
      .lt       (cell_lt[g]),
      .eq       (cell_eq[g])
    );
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign found     = |cell_eq;
  assign full      = count_r == sliru_pkg::CNT_W'(CAP);
  assign dump_last = sliru_pkg::CNT_W'(idx_r) == (count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    ctl.cmd        = sliru_pkg::CMD_HOLD;
    ctl.key        = key;
    ctl.count      = count_r;

    if (in_acc) begin
      out_item_nxt = key;
      out_last_nxt = 1'b1;
      case (op)
        sliru_pkg::OP_INSERT: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_status_nxt = sliru_pkg::STATUS_FULL;
            out_count_nxt  = count_r;
          end else begin
            ctl.cmd        = sliru_pkg::CMD_INSERT;
            count_nxt      = count_r + 1'b1;
            out_status_nxt = sliru_pkg::STATUS_INSERTED;
            out_count_nxt  = count_r + 1'b1;
          end
        end
        sliru_pkg::OP_REMOVE: begin
          out_valid_nxt = 1'b1;
          if (found) begin
            ctl.cmd        = sliru_pkg::CMD_REMOVE;
            count_nxt      = count_r - 1'b1;
            out_status_nxt = sliru_pkg::STATUS_REMOVED;
            out_count_nxt  = count_r - 1'b1;
          end else begin
            out_status_nxt = sliru_pkg::STATUS_NOT_FOUND;
            out_count_nxt  = count_r;
          end
        end
        sliru_pkg::OP_DUMP: begin
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sliru_pkg::STATUS_EMPTY;
            out_item_nxt   = '0;
            out_count_nxt  = '0;
          end else begin
            state_nxt = ST_DUMP;
            idx_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_DUMP && out_free) begin
      ctl.cmd        = sliru_pkg::CMD_ROTATE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = sliru_pkg::STATUS_DUMPED;
      out_item_nxt   = cell_val[0];
      out_count_nxt  = count_r;
      out_last_nxt   = dump_last;
      idx_nxt        = idx_r + 1'b1;
      if (dump_last) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = sliru_pkg::OUT_TDATA_W'({sliru_pkg::COUNT_W'(out_count_r),
                                              out_item_r, out_status_r});

endmodule

### tb/sorted_list_insert_remove_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_list_insert_remove_unit: a directed table of operations,
// then random phases of inserts, removes, dumps and unused codes checked against a sorted-queue predictor.
// Depends on sliru_pkg and the unit's RTL.
module sorted_list_insert_remove_unit_tb;
  import sliru_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam int              RANDOM_ITEMS   = 446;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              DRAIN_CYCLES   = 40;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] item;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } list_result_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    bit                       typed;
    list_result_t             want;
  } list_op_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic signed [DATA_W-1:0] sorted_vals[$];
  list_result_t             step_results[$];
  list_result_t             expected_results[$];
  list_op_t                 directed_ops[$];

  int errors         = 0;
  int results_seen   = 0;
  int ops_sent       = 0;
  int ops_ignored    = 0;
  int full_seen      = 0;
  int not_found_seen = 0;
  int empty_seen     = 0;
  int idle_cycles    = 0;
  int rx_hold        = 0;
  bit steady         = 1'b0;

  sorted_list_insert_remove_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int stall_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void note_result(input logic [STAT_W-1:0] status,
                                      input logic signed [DATA_W-1:0] item,
                                      input int count, input bit last);
    list_result_t r;
    r.status = status;
    r.item   = item;
    r.count  = count[COUNT_W-1:0];
    r.last   = last;
    step_results.push_back(r);
  endfunction

  function automatic void apply_operation(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] val);
    int pos;
    int n;
    step_results.delete();
    n   = sorted_vals.size();
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (n >= CAPACITY) begin
          full_seen++;
          note_result(STATUS_FULL, val, n, 1'b1);
        end else begin
          while (pos < n && sorted_vals[pos] < val) pos++;
          sorted_vals.insert(pos, val);
          note_result(STATUS_INSERTED, val, n + 1, 1'b1);
        end
      end
      OP_REMOVE: begin
        while (pos < n && sorted_vals[pos] != val) pos++;
        if (pos == n) begin
          not_found_seen++;
          note_result(STATUS_NOT_FOUND, val, n, 1'b1);
        end else begin
          sorted_vals.delete(pos);
          note_result(STATUS_REMOVED, val, n - 1, 1'b1);
        end
      end
      OP_DUMP: begin
        if (n == 0) begin
          empty_seen++;
          note_result(STATUS_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) note_result(STATUS_DUMPED, sorted_vals[i], n, i == n - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic list_op_t plain_op(input logic [OP_W-1:0] op,
                                        input logic signed [DATA_W-1:0] val);
    list_op_t t;
    t.op    = op;
    t.val   = val;
    t.typed = 1'b0;
    t.want  = '0;
    return t;
  endfunction

  function automatic list_op_t checked_op(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [STAT_W-1:0] status,
                                          input logic signed [DATA_W-1:0] item,
                                          input logic [COUNT_W-1:0] count);
    list_op_t t;
    t.op          = op;
    t.val         = val;
    t.typed       = 1'b1;
    t.want.status = status;
    t.want.item   = item;
    t.want.count  = count;
    t.want.last   = 1'b1;
    return t;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 20)) - 10;
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic list_op_t random_op(input phase_kind_t kind);
    int r;
    int ins_pct;
    logic signed [DATA_W-1:0] v;
    r       = $urandom_range(0, 99);
    ins_pct = (kind == PH_FILL) ? 80 : (kind == PH_DRAIN) ? 20 : 48;
    if (r < 3) return plain_op(OP_UNUSED, $urandom);
    if (r < 10) return plain_op(OP_DUMP, $urandom);
    if (r < 10 + ins_pct) return plain_op(OP_INSERT, pick_value());
    v = pick_value();
    if (sorted_vals.size() > 0 && $urandom_range(0, 3) != 0)
      v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
    return plain_op(OP_REMOVE, v);
  endfunction

  task automatic issue_op(input list_op_t t);
    int gap;
    gap = steady ? 0 : (($urandom_range(0, 9) < 7) ? 0 : stall_length());
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - DATA_W - OP_W){1'b0}}, t.val, t.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_operation(t.op, t.val);
    if (t.op == OP_UNUSED) ops_ignored++;
    else ops_sent++;
    if (t.typed) expected_results.push_back(t.want);
    else foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // hold the result side off at random
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (!steady && rst_n && $urandom_range(0, 99) < 20) begin
      rx_hold    <= stall_length() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[STAT_W-1:0];
      got.item   = out_tdata[STAT_W+DATA_W-1:STAT_W];
      got.count  = out_tdata[STAT_W+DATA_W+COUNT_W-1:STAT_W+DATA_W];
      got.last   = out_tlast;
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction status %0d item %0d count %0d last %0b",
                 $time, got.status, got.item, got.count, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.item !== want.item) begin
          errors++;
          $display("%0t: item expected %0d got %0d", $time, want.item, got.item);
        end
        if (got.count !== want.count) begin
          errors++;
          $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    phase_kind_t kind;
    int          phase_len;
    int          rand_done;
    list_op_t    t;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_ops.push_back(checked_op(OP_DUMP, 0, STATUS_EMPTY, 0, 0));
    directed_ops.push_back(checked_op(OP_REMOVE, 5, STATUS_NOT_FOUND, 5, 0));
    directed_ops.push_back(checked_op(OP_INSERT, VAL_MAX, STATUS_INSERTED, VAL_MAX, 1));
    directed_ops.push_back(checked_op(OP_INSERT, VAL_MIN, STATUS_INSERTED, VAL_MIN, 2));
    directed_ops.push_back(checked_op(OP_INSERT, 0, STATUS_INSERTED, 0, 3));
    directed_ops.push_back(checked_op(OP_INSERT, -1, STATUS_INSERTED, -1, 4));
    directed_ops.push_back(checked_op(OP_INSERT, -1, STATUS_INSERTED, -1, 5));
    directed_ops.push_back(checked_op(OP_INSERT, 1, STATUS_INSERTED, 1, 6));
    directed_ops.push_back(plain_op(OP_UNUSED, 32'hFFFF_FFFF));
    directed_ops.push_back(plain_op(OP_DUMP, 32'hFFFF_FFFF));
    directed_ops.push_back(checked_op(OP_REMOVE, 7, STATUS_NOT_FOUND, 7, 6));
    directed_ops.push_back(checked_op(OP_REMOVE, -1, STATUS_REMOVED, -1, 5));
    directed_ops.push_back(checked_op(OP_REMOVE, VAL_MIN, STATUS_REMOVED, VAL_MIN, 4));
    directed_ops.push_back(plain_op(OP_INSERT, 32'sh5555_5555));
    directed_ops.push_back(plain_op(OP_INSERT, 32'shAAAA_AAAA));
    directed_ops.push_back(plain_op(OP_DUMP, 0));
    directed_ops.push_back(checked_op(OP_REMOVE, VAL_MAX, STATUS_REMOVED, VAL_MAX, 5));
    directed_ops.push_back(plain_op(OP_UNUSED, 0));
    directed_ops.push_back(plain_op(OP_REMOVE, -1));
    directed_ops.push_back(plain_op(OP_REMOVE, 0));
    directed_ops.push_back(plain_op(OP_REMOVE, 1));
    directed_ops.push_back(plain_op(OP_REMOVE, 32'sh5555_5555));
    directed_ops.push_back(plain_op(OP_REMOVE, 32'shAAAA_AAAA));
    directed_ops.push_back(checked_op(OP_DUMP, 32'sh1234_5678, STATUS_EMPTY, 0, 0));
    foreach (directed_ops[i]) issue_op(directed_ops[i]);

    // open with a long fill phase that pushes the store towards overflow
    kind      = PH_FILL;
    phase_len = 60;
    rand_done = 0;
    while (rand_done < RANDOM_ITEMS) begin
      steady <= ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (rand_done < RANDOM_ITEMS) begin
          t = random_op(kind);
          issue_op(t);
          rand_done++;
        end
      end
      kind      = phase_kind_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 60);
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d list operations and %0d unused codes, %0d results compared.",
             ops_sent, ops_ignored, results_seen);
    $display("Inserts into a full store %0d, removes of absent values %0d, empty dumps %0d.",
             full_seen, not_found_seen, empty_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
